// ===== hw/rtl/pea_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer event accumulator package
// Shared command codes, event codes, queue word and report types.
// ----------------------------------------------------------------------------
package pea_pkg;

  localparam int FIFO_DEPTH_DEF = 128;
  localparam int CMDQ_DEPTH = 2;

  localparam logic [1:0] CMD_EVENT = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_SET   = 2'd2;

  localparam logic [15:0] EV_SYN = 16'h0000;
  localparam logic [15:0] EV_KEY = 16'h0001;
  localparam logic [15:0] EV_REL = 16'h0002;

  localparam logic [15:0] REL_X            = 16'h0000;
  localparam logic [15:0] REL_Y            = 16'h0001;
  localparam logic [15:0] SYNC_CODE_REPORT = 16'h0000;
  localparam logic [15:0] KEY_CODE_LEFT    = 16'h0110;
  localparam logic [15:0] KEY_CODE_RIGHT   = 16'h0111;
  localparam logic [15:0] KEY_CODE_MIDDLE  = 16'h0112;

  localparam logic [2:0] BIT_LEFT   = 3'h1;
  localparam logic [2:0] BIT_RIGHT  = 3'h2;
  localparam logic [2:0] BIT_MIDDLE = 3'h4;

  localparam logic [31:0] KEY_PRESSED  = 32'd1;
  localparam logic [31:0] KEY_RELEASED = 32'd0;

  localparam logic [6:0] MAX_POP = 7'd64;

  typedef enum logic {
    KIND_SINGLE,
    KIND_POP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [6:0]         count;
    logic               dropped;
    logic signed [31:0] abs_x;
    logic signed [31:0] abs_y;
    logic [2:0]         buttons;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic [2:0]         buttons;
  } report_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_LOAD,
    BK_SEND
  } back_state_t;

endpackage

// ===== hw/rtl/pea_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer event accumulator channels
// Input word channel and result word channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pea_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [15:0]        event_type;
  logic [15:0]        event_code;
  logic signed [31:0] event_value;
  logic [6:0]         want_count;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;

  modport source (output valid, command, event_type, event_code, event_value,
                  want_count, new_x, new_y, input ready);
  modport sink (input valid, command, event_type, event_code, event_value,
                want_count, new_x, new_y, output ready);
endinterface

interface pea_out_if;
  logic               valid;
  logic               ready;
  logic               report_valid;
  logic signed [31:0] report_dx;
  logic signed [31:0] report_dy;
  logic [2:0]         report_buttons;
  logic               last_report;
  logic signed [31:0] abs_x;
  logic signed [31:0] abs_y;
  logic [2:0]         current_buttons;
  logic               report_dropped;

  modport source (output valid, report_valid, report_dx, report_dy, report_buttons,
                  last_report, abs_x, abs_y, current_buttons, report_dropped,
                  input ready);
  modport sink (input valid, report_valid, report_dx, report_dy, report_buttons,
                last_report, abs_x, abs_y, current_buttons, report_dropped,
                output ready);
endinterface

// ===== hw/rtl/pea_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer event accumulator front end
// Accepts input words, updates position, motion and buttons, writes reports
// into the ring and queues one work word per input for the back end.
// ----------------------------------------------------------------------------
module pea_front #(
  parameter int FIFO_DEPTH = pea_pkg::FIFO_DEPTH_DEF,
  localparam int PTR_W = $clog2(FIFO_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  pea_in_if.sink            evt,
  output pea_pkg::cmd_t     q_data,
  output logic              q_push,
  input  logic              q_ready,
  output logic              wr_en,
  output logic [PTR_W-1:0]  wr_addr,
  output pea_pkg::report_t  wr_data,
  output logic [PTR_W-1:0]  wp,
  input  logic [PTR_W-1:0]  rp,
  input  logic              pop_done
);

  logic signed [31:0] position_x, position_x_next;
  logic signed [31:0] position_y, position_y_next;
  logic signed [31:0] motion_x, motion_x_next;
  logic signed [31:0] motion_y, motion_y_next;
  logic [2:0]         button_bits, button_bits_next;
  logic [PTR_W-1:0]   wp_next, wp_adv;
  logic               pop_busy, pop_busy_next;
  logic               accept;
  logic               dropped;
  logic [2:0]         key_bit;

  assign evt.ready = q_ready && !pop_busy;
  assign accept    = evt.valid && evt.ready;
  assign wp_adv    = (wp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign wr_addr   = wp;
  assign wr_data   = '{dx: motion_x, dy: motion_y, buttons: button_bits};

  always_comb begin
    priority if (evt.event_code == pea_pkg::KEY_CODE_LEFT) begin
      key_bit = pea_pkg::BIT_LEFT;
    end else if (evt.event_code == pea_pkg::KEY_CODE_RIGHT) begin
      key_bit = pea_pkg::BIT_RIGHT;
    end else if (evt.event_code == pea_pkg::KEY_CODE_MIDDLE) begin
      key_bit = pea_pkg::BIT_MIDDLE;
    end else begin
      key_bit = '0;
    end
  end

  always_comb begin
    position_x_next  = position_x;
    position_y_next  = position_y;
    motion_x_next    = motion_x;
    motion_y_next    = motion_y;
    button_bits_next = button_bits;
    wp_next          = wp;
    pop_busy_next    = pop_busy && !pop_done;
    wr_en            = 1'b0;
    dropped          = 1'b0;
    if (accept) begin
      unique case (evt.command)
        pea_pkg::CMD_EVENT: begin
          priority if (evt.event_type == pea_pkg::EV_REL) begin
            if (evt.event_code == pea_pkg::REL_X) begin
              motion_x_next   = motion_x + evt.event_value;
              position_x_next = position_x + evt.event_value;
            end else if (evt.event_code == pea_pkg::REL_Y) begin
              motion_y_next   = motion_y + evt.event_value;
              position_y_next = position_y + evt.event_value;
            end
          end else if (evt.event_type == pea_pkg::EV_KEY) begin
            if (evt.event_value == pea_pkg::KEY_PRESSED) begin
              button_bits_next = button_bits | key_bit;
            end else if (evt.event_value == pea_pkg::KEY_RELEASED) begin
              button_bits_next = button_bits & ~key_bit;
            end
          end else if (evt.event_type == pea_pkg::EV_SYN &&
                       evt.event_code == pea_pkg::SYNC_CODE_REPORT) begin
            if (wp_adv == rp) begin
              dropped = 1'b1;
            end else begin
              wr_en         = 1'b1;
              wp_next       = wp_adv;
              motion_x_next = '0;
              motion_y_next = '0;
            end
          end
        end
        pea_pkg::CMD_POP: begin
          pop_busy_next = 1'b1;
        end
        pea_pkg::CMD_SET: begin
          position_x_next = evt.new_x;
          position_y_next = evt.new_y;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    q_push          = accept;
    q_data.kind     = (evt.command == pea_pkg::CMD_POP) ? pea_pkg::KIND_POP
                                                       : pea_pkg::KIND_SINGLE;
    q_data.count    = (evt.want_count > pea_pkg::MAX_POP) ? pea_pkg::MAX_POP
                                                         : evt.want_count;
    q_data.dropped  = dropped;
    q_data.abs_x    = position_x_next;
    q_data.abs_y    = position_y_next;
    q_data.buttons  = button_bits_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_x  <= '0;
      position_y  <= '0;
      motion_x    <= '0;
      motion_y    <= '0;
      button_bits <= '0;
      wp          <= '0;
      pop_busy    <= 1'b0;
    end else begin
      position_x  <= position_x_next;
      position_y  <= position_y_next;
      motion_x    <= motion_x_next;
      motion_y    <= motion_y_next;
      button_bits <= button_bits_next;
      wp          <= wp_next;
      pop_busy    <= pop_busy_next;
    end
  end

endmodule

// ===== hw/rtl/pea_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer event accumulator work queue
// Short queue of work words between the front end and the back end.
// ----------------------------------------------------------------------------
module pea_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pea_pkg::cmd_t push_data,
  output logic          push_ready,
  input  logic          take,
  output logic          take_valid,
  output pea_pkg::cmd_t take_data
);

  localparam int AW = $clog2(pea_pkg::CMDQ_DEPTH);
  localparam int CW = $clog2(pea_pkg::CMDQ_DEPTH + 1);

  pea_pkg::cmd_t slots [pea_pkg::CMDQ_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push, do_take;

  assign push_ready = (fill != CW'(pea_pkg::CMDQ_DEPTH));
  assign take_valid = (fill != '0);
  assign take_data  = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_take    = take && take_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(pea_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= (rd_ptr == AW'(pea_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_take) begin
        fill <= fill + 1'b1;
      end else if (do_take && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/pea_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer event accumulator back end
// Holds the report ring, drains it for pop work words and drives the result
// word register.
// ----------------------------------------------------------------------------
module pea_back #(
  parameter int FIFO_DEPTH = pea_pkg::FIFO_DEPTH_DEF,
  localparam int PTR_W = $clog2(FIFO_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  pea_pkg::cmd_t     cmd,
  output logic              cmd_take,
  input  logic              wr_en,
  input  logic [PTR_W-1:0]  wr_addr,
  input  pea_pkg::report_t  wr_data,
  input  logic [PTR_W-1:0]  wp,
  output logic [PTR_W-1:0]  rp,
  output logic              pop_done,
  pea_out_if.source         res
);

  pea_pkg::report_t     ring [FIFO_DEPTH];
  pea_pkg::report_t     rdata;
  pea_pkg::back_state_t state, state_next;
  pea_pkg::cmd_t        cmd_r;
  logic [6:0]           remaining;
  logic [PTR_W-1:0]     rp_adv;
  logic                 load_single, load_rep;

  logic                 out_report_valid;
  pea_pkg::report_t     out_rep;
  logic                 out_last;
  logic signed [31:0]   out_abs_x, out_abs_y;
  logic [2:0]           out_buttons;
  logic                 out_dropped;

  assign rp_adv = (rp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= wr_data;
    end
    rdata <= ring[rp];
  end

  always_comb begin
    state_next  = state;
    cmd_take    = 1'b0;
    load_single = 1'b0;
    load_rep    = 1'b0;
    pop_done    = 1'b0;
    unique case (state)
      pea_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          if (cmd.kind == pea_pkg::KIND_POP && cmd.count != '0 && rp != wp) begin
            state_next = pea_pkg::BK_READ;
          end else begin
            load_single = 1'b1;
            state_next  = pea_pkg::BK_SEND;
          end
        end
      end
      pea_pkg::BK_READ: begin
        state_next = pea_pkg::BK_LOAD;
      end
      pea_pkg::BK_LOAD: begin
        load_rep   = 1'b1;
        state_next = pea_pkg::BK_SEND;
      end
      pea_pkg::BK_SEND: begin
        if (res.ready) begin
          if (out_last) begin
            pop_done   = (cmd_r.kind == pea_pkg::KIND_POP);
            state_next = pea_pkg::BK_IDLE;
          end else begin
            state_next = pea_pkg::BK_READ;
          end
        end
      end
      default: begin
        state_next = pea_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pea_pkg::BK_IDLE;
      rp    <= '0;
    end else begin
      state <= state_next;
      if (load_rep) begin
        rp <= rp_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_r     <= cmd;
      remaining <= cmd.count;
    end else if (load_rep) begin
      remaining <= remaining - 1'b1;
    end
    if (load_single) begin
      out_report_valid <= 1'b0;
      out_rep          <= '0;
      out_last         <= 1'b1;
      out_abs_x        <= cmd.abs_x;
      out_abs_y        <= cmd.abs_y;
      out_buttons      <= cmd.buttons;
      out_dropped      <= cmd.dropped;
    end else if (load_rep) begin
      out_report_valid <= 1'b1;
      out_rep          <= rdata;
      out_last         <= (remaining == 7'd1) || (rp_adv == wp);
      out_abs_x        <= cmd_r.abs_x;
      out_abs_y        <= cmd_r.abs_y;
      out_buttons      <= cmd_r.buttons;
      out_dropped      <= 1'b0;
    end
  end

  assign res.valid           = (state == pea_pkg::BK_SEND);
  assign res.report_valid    = out_report_valid;
  assign res.report_dx       = out_rep.dx;
  assign res.report_dy       = out_rep.dy;
  assign res.report_buttons  = out_rep.buttons;
  assign res.last_report     = out_last;
  assign res.abs_x           = out_abs_x;
  assign res.abs_y           = out_abs_y;
  assign res.current_buttons = out_buttons;
  assign res.report_dropped  = out_dropped;

  a_load_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == pea_pkg::BK_LOAD |-> rp != wp)
    else $error("Report read from an empty ring.");

  a_load_budget: assert property (@(posedge clk) disable iff (rst)
    state == pea_pkg::BK_LOAD |-> remaining != '0)
    else $error("Pop returned more reports than requested.");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (state == pea_pkg::BK_SEND && !out_report_valid) |-> out_last)
    else $error("Result without a report is not marked last.");

  a_pop_done: assert property (@(posedge clk) disable iff (rst)
    pop_done |-> (state == pea_pkg::BK_SEND && res.ready && out_last))
    else $error("Pop finished without its last result word.");

endmodule

// ===== hw/rtl/pointer_event_accumulator_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer event accumulator with report FIFO
// Top level joining the front end, the work queue and the back end.
// ----------------------------------------------------------------------------
// Each input word gives result words in order. An event, set or other word is
// taken by the front end into the work queue; the back end loads its single
// result word into the result register and takes the next work word only after
// that result word has been delivered. A pop word gives one result word per
// report, each through ring read, output load and send steps, because the ring
// memory has a registered read port; the input channel takes no further word
// until the last result word of a pop has been delivered. The ring holds at
// most FIFO_DEPTH - 1 reports and needs no clearing after reset.
module pointer_event_accumulator_fifo #(
  parameter int FIFO_DEPTH = pea_pkg::FIFO_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  pea_in_if.sink    evt,
  pea_out_if.source res
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  pea_pkg::cmd_t    q_in, q_out;
  logic             q_push, q_ready, q_valid, q_take;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr, wp, rp;
  pea_pkg::report_t wr_data;
  logic             pop_done;

  pea_front #(.FIFO_DEPTH(FIFO_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .evt      (evt),
    .q_data   (q_in),
    .q_push   (q_push),
    .q_ready  (q_ready),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .wp       (wp),
    .rp       (rp),
    .pop_done (pop_done)
  );

  pea_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .push_ready (q_ready),
    .take       (q_take),
    .take_valid (q_valid),
    .take_data  (q_out)
  );

  pea_back #(.FIFO_DEPTH(FIFO_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_out),
    .cmd_take  (q_take),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .wp        (wp),
    .rp        (rp),
    .pop_done  (pop_done),
    .res       (res)
  );

endmodule
